>>> hdl/scla_pkg.sv
// Shared constants, the result type and the US QWERTY set-1 key tables.
package scla_pkg;

	localparam int LINE_CAP_DEFAULT = 63;

	localparam int ACTION_W = 2;
	localparam int CHAR_W   = 7;
	localparam int INDEX_W  = 6;

	localparam logic [ACTION_W-1:0] ACT_ECHO      = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_BACKSPACE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_ENTER     = 2'd2;

	localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
	localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
	localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
	localparam logic [7:0] SC_CAPS_LOCK    = 8'h3A;
	localparam logic [7:0] SC_LETTER_FIRST = 8'h10;
	localparam logic [7:0] SC_LETTER_LAST  = 8'h32;
	localparam logic [7:0] SC_MAP_SIZE     = 8'd58;

	localparam logic [CHAR_W-1:0] CH_NONE      = 7'h00;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 7'h08;
	localparam logic [CHAR_W-1:0] CH_ENTER     = 7'h0A;

	typedef struct packed {
		logic                emit;
		logic [ACTION_W-1:0] action;
		logic [CHAR_W-1:0]   char_code;
		logic                stored;
		logic [INDEX_W-1:0]  store_index;
		logic [INDEX_W-1:0]  line_length;
	} result_t;

	// Unshifted table; codes without a key give zero.
	function automatic logic [CHAR_W-1:0] plain_char(input logic [5:0] code);
		logic [CHAR_W-1:0] ch;
		unique case (code)
			6'd1:  ch = 7'h1B;
			6'd2:  ch = 7'h31;
			6'd3:  ch = 7'h32;
			6'd4:  ch = 7'h33;
			6'd5:  ch = 7'h34;
			6'd6:  ch = 7'h35;
			6'd7:  ch = 7'h36;
			6'd8:  ch = 7'h37;
			6'd9:  ch = 7'h38;
			6'd10: ch = 7'h39;
			6'd11: ch = 7'h30;
			6'd12: ch = 7'h2D;
			6'd13: ch = 7'h3D;
			6'd14: ch = 7'h08;
			6'd15: ch = 7'h09;
			6'd16: ch = 7'h71;
			6'd17: ch = 7'h77;
			6'd18: ch = 7'h65;
			6'd19: ch = 7'h72;
			6'd20: ch = 7'h74;
			6'd21: ch = 7'h79;
			6'd22: ch = 7'h75;
			6'd23: ch = 7'h69;
			6'd24: ch = 7'h6F;
			6'd25: ch = 7'h70;
			6'd26: ch = 7'h5B;
			6'd27: ch = 7'h5D;
			6'd28: ch = 7'h0A;
			6'd30: ch = 7'h61;
			6'd31: ch = 7'h73;
			6'd32: ch = 7'h64;
			6'd33: ch = 7'h66;
			6'd34: ch = 7'h67;
			6'd35: ch = 7'h68;
			6'd36: ch = 7'h6A;
			6'd37: ch = 7'h6B;
			6'd38: ch = 7'h6C;
			6'd39: ch = 7'h3B;
			6'd40: ch = 7'h27;
			6'd41: ch = 7'h60;
			6'd43: ch = 7'h5C;
			6'd44: ch = 7'h7A;
			6'd45: ch = 7'h78;
			6'd46: ch = 7'h63;
			6'd47: ch = 7'h76;
			6'd48: ch = 7'h62;
			6'd49: ch = 7'h6E;
			6'd50: ch = 7'h6D;
			6'd51: ch = 7'h2C;
			6'd52: ch = 7'h2E;
			6'd53: ch = 7'h2F;
			6'd55: ch = 7'h2A;
			6'd57: ch = 7'h20;
			default: ch = CH_NONE;
		endcase
		return ch;
	endfunction

	// Shifted table; codes without a key give zero.
	function automatic logic [CHAR_W-1:0] upper_char(input logic [5:0] code);
		logic [CHAR_W-1:0] ch;
		unique case (code)
			6'd1:  ch = 7'h1B;
			6'd2:  ch = 7'h21;
			6'd3:  ch = 7'h40;
			6'd4:  ch = 7'h23;
			6'd5:  ch = 7'h24;
			6'd6:  ch = 7'h25;
			6'd7:  ch = 7'h5E;
			6'd8:  ch = 7'h26;
			6'd9:  ch = 7'h2A;
			6'd10: ch = 7'h28;
			6'd11: ch = 7'h29;
			6'd12: ch = 7'h5F;
			6'd13: ch = 7'h2B;
			6'd14: ch = 7'h08;
			6'd15: ch = 7'h09;
			6'd16: ch = 7'h51;
			6'd17: ch = 7'h57;
			6'd18: ch = 7'h45;
			6'd19: ch = 7'h52;
			6'd20: ch = 7'h54;
			6'd21: ch = 7'h59;
			6'd22: ch = 7'h55;
			6'd23: ch = 7'h49;
			6'd24: ch = 7'h4F;
			6'd25: ch = 7'h50;
			6'd26: ch = 7'h7B;
			6'd27: ch = 7'h7D;
			6'd28: ch = 7'h0A;
			6'd30: ch = 7'h41;
			6'd31: ch = 7'h53;
			6'd32: ch = 7'h44;
			6'd33: ch = 7'h46;
			6'd34: ch = 7'h47;
			6'd35: ch = 7'h48;
			6'd36: ch = 7'h4A;
			6'd37: ch = 7'h4B;
			6'd38: ch = 7'h4C;
			6'd39: ch = 7'h3A;
			6'd40: ch = 7'h22;
			6'd41: ch = 7'h7E;
			6'd43: ch = 7'h7C;
			6'd44: ch = 7'h5A;
			6'd45: ch = 7'h58;
			6'd46: ch = 7'h43;
			6'd47: ch = 7'h56;
			6'd48: ch = 7'h42;
			6'd49: ch = 7'h4E;
			6'd50: ch = 7'h4D;
			6'd51: ch = 7'h3C;
			6'd52: ch = 7'h3E;
			6'd53: ch = 7'h3F;
			6'd55: ch = 7'h2A;
			6'd57: ch = 7'h20;
			default: ch = CH_NONE;
		endcase
		return ch;
	endfunction

endpackage

>>> hdl/scla_decode.sv
// Scancode decode: modifier tracking, key table lookup and line count update.
module scla_decode import scla_pkg::*; #(
	parameter int LINE_CAP = LINE_CAP_DEFAULT,
	parameter int CNT_W    = $clog2(LINE_CAP + 1)
) (
	input  logic [7:0]       scancode,
	input  logic             shift_held,
	input  logic             caps_on,
	input  logic [CNT_W-1:0] held_count,
	output logic             shift_next,
	output logic             caps_next,
	output logic [CNT_W-1:0] count_next,
	output result_t          result
);

	localparam logic [CNT_W-1:0] CAP = CNT_W'(LINE_CAP);

	logic              upper;
	logic [CHAR_W-1:0] ch;

	// Counts are reported modulo 64 whatever the counter width.
	function automatic logic [INDEX_W-1:0] low_bits(input logic [CNT_W-1:0] cnt);
		logic [CNT_W+INDEX_W-1:0] wide;
		wide = {{INDEX_W{1'b0}}, cnt};
		return wide[INDEX_W-1:0];
	endfunction

	always_comb begin
		upper = shift_held;
		if (scancode >= SC_LETTER_FIRST && scancode <= SC_LETTER_LAST) begin
			upper = shift_held ^ caps_on;
		end
		ch = upper ? upper_char(scancode[5:0]) : plain_char(scancode[5:0]);
	end

	always_comb begin
		shift_next = shift_held;
		caps_next  = caps_on;
		count_next = held_count;
		result     = '0;
		if (scancode == SC_LSHIFT_MAKE || scancode == SC_RSHIFT_MAKE) begin
			shift_next = 1'b1;
		end else if (scancode == SC_LSHIFT_BREAK || scancode == SC_RSHIFT_BREAK) begin
			shift_next = 1'b0;
		end else if (scancode == SC_CAPS_LOCK) begin
			caps_next = ~caps_on;
		end else if (!scancode[7] && scancode < SC_MAP_SIZE && ch != CH_NONE) begin
			result.emit      = 1'b1;
			result.char_code = ch;
			if (ch == CH_BACKSPACE) begin
				if (held_count != '0) begin
					count_next = held_count - 1'b1;
				end
				result.action      = ACT_BACKSPACE;
				result.line_length = low_bits(count_next);
			end else if (ch == CH_ENTER) begin
				result.action      = ACT_ENTER;
				result.line_length = low_bits(held_count);
				count_next         = '0;
			end else if (held_count < CAP) begin
				count_next         = held_count + 1'b1;
				result.action      = ACT_ECHO;
				result.stored      = 1'b1;
				result.store_index = low_bits(held_count);
				result.line_length = low_bits(count_next);
			end else begin
				result.action      = ACT_ECHO;
				result.line_length = low_bits(held_count);
			end
		end
	end

endmodule

>>> hdl/scancode_to_ascii_line_editor_top.sv
// Top level of the set-1 scancode to ASCII line editor.
//
// Input channel: in_valid, in_stall and scancode. A byte is transferred at a
// rising edge with in_valid high and in_stall low. Each byte is one raw set-1
// code; shift, caps lock and release codes only update internal flags.
// Output channel: out_valid, out_stall and the result fields. A result is
// transferred at a rising edge with out_valid high and out_stall low. Codes
// that map to nothing, releases and modifiers give no result at all.
// One byte is taken every cycle while the receiver does not stall. A byte is
// captured in the input register, is decoded against the current shift, caps
// and line count state, and its result is loaded into the output register,
// which drives out_valid and the result fields. The rate is set by the single
// decode stage, which updates the state for the next byte in the same cycle.
// While the receiver stalls with a result waiting, nothing leaves the input
// register and in_stall rises once that register is full; bytes that give no
// result wait there too until the waiting result has been taken.
// Reset clears shift and caps lock, empties the line and both registers.
module scancode_to_ascii_line_editor_top import scla_pkg::*; #(
	parameter int LINE_CAP = LINE_CAP_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          scancode,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [ACTION_W-1:0] action,
	output logic [CHAR_W-1:0]   char_code,
	output logic                stored,
	output logic [INDEX_W-1:0]  store_index,
	output logic [INDEX_W-1:0]  line_length
);

	localparam int CNT_W = $clog2(LINE_CAP + 1);

	logic             valid_s1;
	logic [7:0]       scancode_s1;
	logic             shift_q;
	logic             caps_q;
	logic [CNT_W-1:0] count_q;
	logic             shift_next;
	logic             caps_next;
	logic [CNT_W-1:0] count_next;
	result_t          result;
	result_t          out_q;
	logic             out_valid_q;
	logic             advance;

	// The decode stage moves on whenever the output register is free or drains.
	assign advance  = !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;

	scla_decode #(
		.LINE_CAP(LINE_CAP),
		.CNT_W   (CNT_W)
	) u_decode (
		.scancode  (scancode_s1),
		.shift_held(shift_q),
		.caps_on   (caps_q),
		.held_count(count_q),
		.shift_next(shift_next),
		.caps_next (caps_next),
		.count_next(count_next),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			scancode_s1 <= scancode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			caps_q  <= 1'b0;
			count_q <= '0;
		end else if (valid_s1 && advance) begin
			shift_q <= shift_next;
			caps_q  <= caps_next;
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && result.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && result.emit) begin
			out_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign action      = out_q.action;
	assign char_code   = out_q.char_code;
	assign stored      = out_q.stored;
	assign store_index = out_q.store_index;
	assign line_length = out_q.line_length;

endmodule

>>> hdl/scla_checker.sv
// Port-level checks for the line editor, bound to the top level.
module scla_checker import scla_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input logic [ACTION_W-1:0] action,
	input logic [CHAR_W-1:0]   char_code,
	input logic                stored,
	input logic [INDEX_W-1:0]  store_index,
	input logic [INDEX_W-1:0]  line_length
);

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while the receiver stalled");

	a_action_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (action == ACT_ECHO || action == ACT_BACKSPACE || action == ACT_ENTER))
		else $error("unknown action code");

	a_store_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stored |-> action == ACT_ECHO
			&& line_length == INDEX_W'(store_index + 1'b1))
		else $error("stored character does not advance the line length");

	a_control_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == ACT_BACKSPACE || action == ACT_ENTER)
			|-> !stored && store_index == '0
			&& (char_code == CH_BACKSPACE || char_code == CH_ENTER))
		else $error("backspace or enter result carries store data");

endmodule

bind scancode_to_ascii_line_editor_top scla_checker u_scla_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.action     (action),
	.char_code  (char_code),
	.stored     (stored),
	.store_index(store_index),
	.line_length(line_length)
);

>>> bench/testbench.sv
// Self-checking bench for the scancode line editor: a directed key table, then random typed lines.
module testbench;
	import scla_pkg::*;

	localparam logic [7:0] KEY_NONE      = 8'h00;
	localparam logic [7:0] KEY_ESC       = 8'h01;
	localparam logic [7:0] KEY_ONE       = 8'h02;
	localparam logic [7:0] KEY_BACKSPACE = 8'h0E;
	localparam logic [7:0] KEY_TAB       = 8'h0F;
	localparam logic [7:0] KEY_Q         = 8'h10;
	localparam logic [7:0] KEY_LBRACKET  = 8'h1A;
	localparam logic [7:0] KEY_ENTER     = 8'h1C;
	localparam logic [7:0] KEY_A         = 8'h1E;
	localparam logic [7:0] KEY_SLASH     = 8'h35;
	localparam logic [7:0] KEY_STAR      = 8'h37;
	localparam logic [7:0] KEY_SPACE     = 8'h39;
	localparam logic [7:0] KEY_F1        = 8'h3B;
	localparam logic [7:0] KEY_TOP_PRESS = 8'h7F;
	localparam logic [7:0] KEY_RELEASE   = 8'h80;
	localparam logic [7:0] KEY_ALL_ONES  = 8'hFF;

	localparam int TARGET_ITEMS  = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 800000;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [CHAR_W-1:0]   char_code;
		logic                stored;
		logic [INDEX_W-1:0]  store_index;
		logic [INDEX_W-1:0]  line_length;
	} line_event_t;

	typedef struct packed {
		logic [7:0]  code;
		logic        typed;
		logic        emit;
		line_event_t ev;
	} key_row_t;

	// US QWERTY set-1 layout, unshifted and shifted.
	logic [7:0] lower_keys [0:57] = '{
		8'h00, 8'h1B, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'h08,
		8'h09, "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'h0A,
		8'h00, "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", "'", 8'h60,
		8'h00, 8'h5C, "z", "x", "c", "v", "b", "n", "m", ",", ".", "/",
		8'h00, "*", 8'h00, " "
	};
	logic [7:0] upper_keys [0:57] = '{
		8'h00, 8'h1B, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'h08,
		8'h09, "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'h0A,
		8'h00, "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'h22, 8'h7E,
		8'h00, 8'h7C, "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?",
		8'h00, "*", 8'h00, " "
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [7:0]          scancode = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [ACTION_W-1:0] action;
	logic [CHAR_W-1:0]   char_code;
	logic                stored;
	logic [INDEX_W-1:0]  store_index;
	logic [INDEX_W-1:0]  line_length;

	// Editor state as the bench expects it.
	bit shift_down;
	bit caps_latched;
	int line_count;

	line_event_t pending_events [$];
	key_row_t    key_table [$];
	logic [7:0]  printable_codes [$];

	int errors;
	int results_expected;
	int items_sent;
	int burst_left;
	int stall_left;
	int stall_mode;
	int cycle_count;
	int lines_typed;
	int n_echo, n_stored, n_full, n_backspace, n_enter;

	scancode_to_ascii_line_editor_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.scancode    (scancode),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.action      (action),
		.char_code   (char_code),
		.stored      (stored),
		.store_index (store_index),
		.line_length (line_length)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycle_count, pending_events.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// Works out the result of one transferred scancode and advances the editor state.
	function automatic bit decode_key(input logic [7:0] code, output line_event_t ev);
		logic [7:0] ch;
		bit upper;
		ev = '0;
		if (code == SC_LSHIFT_MAKE || code == SC_RSHIFT_MAKE) begin
			shift_down = 1'b1;
			return 1'b0;
		end
		if (code == SC_LSHIFT_BREAK || code == SC_RSHIFT_BREAK) begin
			shift_down = 1'b0;
			return 1'b0;
		end
		if (code == SC_CAPS_LOCK) begin
			caps_latched = ~caps_latched;
			return 1'b0;
		end
		if (code[7] || code >= SC_MAP_SIZE)
			return 1'b0;
		// Caps lock reaches every key from Q to M, the punctuation between them included.
		if (code >= SC_LETTER_FIRST && code <= SC_LETTER_LAST)
			upper = shift_down ^ caps_latched;
		else
			upper = shift_down;
		ch = upper ? upper_keys[code] : lower_keys[code];
		if (ch == 8'h00)
			return 1'b0;
		ev.char_code = ch[CHAR_W-1:0];
		if (ev.char_code == CH_BACKSPACE) begin
			if (line_count > 0)
				line_count--;
			ev.action = ACT_BACKSPACE;
			ev.line_length = line_count[INDEX_W-1:0];
		end else if (ev.char_code == CH_ENTER) begin
			ev.action = ACT_ENTER;
			ev.line_length = line_count[INDEX_W-1:0];
			line_count = 0;
		end else begin
			ev.action = ACT_ECHO;
			if (line_count < LINE_CAP_DEFAULT) begin
				ev.stored = 1'b1;
				ev.store_index = line_count[INDEX_W-1:0];
				line_count++;
			end
			ev.line_length = line_count[INDEX_W-1:0];
		end
		return 1'b1;
	endfunction

	function automatic key_row_t typed_row(input logic [7:0] code, input logic emit,
			input logic [ACTION_W-1:0] act, input logic [CHAR_W-1:0] ch,
			input logic st, input logic [INDEX_W-1:0] idx, input logic [INDEX_W-1:0] len);
		key_row_t row;
		row.code = code;
		row.typed = 1'b1;
		row.emit = emit;
		row.ev = {act, ch, st, idx, len};
		return row;
	endfunction

	function automatic key_row_t free_row(input logic [7:0] code);
		key_row_t row;
		row = '0;
		row.code = code;
		return row;
	endfunction

	function automatic void compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Offers one scancode and returns once it has been transferred.
	task automatic send_code(input logic [7:0] code);
		@(negedge clk);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 48);
		end
		in_valid <= 1'b1;
		scancode <= code;
		burst_left--;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic type_key(input logic [7:0] code);
		line_event_t ev;
		send_code(code);
		if (decode_key(code, ev)) begin
			pending_events.push_back(ev);
			results_expected++;
		end
	endtask

	// Holds the sender back until every expected result has come out.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
	endtask

	// One edited line: mostly printable keys, with modifiers, releases and noise mixed in.
	task automatic type_line();
		bit long_line;
		int n;
		int r;
		long_line = ($urandom_range(0, 6) == 0);
		n = long_line ? $urandom_range(66, 90) : $urandom_range(0, 18);
		repeat (n) begin
			// Long lines are kept almost clean so that they run into the full-line case.
			r = (long_line && $urandom_range(0, 19) != 0) ? 0 : $urandom_range(0, 99);
			if (r < 62)
				type_key(printable_codes[$urandom_range(0, printable_codes.size() - 1)]);
			else if (r < 70)
				type_key(KEY_BACKSPACE);
			else if (r < 78) begin
				case ($urandom_range(0, 3))
					0: type_key(SC_LSHIFT_MAKE);
					1: type_key(SC_RSHIFT_MAKE);
					2: type_key(SC_LSHIFT_BREAK);
					default: type_key(SC_RSHIFT_BREAK);
				endcase
			end else if (r < 81)
				type_key(SC_CAPS_LOCK);
			else if (r < 93)
				type_key(KEY_RELEASE | 8'($urandom_range(0, 127)));
			else
				type_key(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 9) != 0)
			type_key(KEY_ENTER);
	endtask

	// The receiver switches between free running, light, heavy and periodic stalling.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 96);
		end
		stall_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ((stall_left % 5) < 2);
		endcase
	end

	always @(posedge clk) begin
		line_event_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected result, action %0h char %0h, none was expected",
					$time, action, char_code);
				errors++;
			end else begin
				want = pending_events.pop_front();
				compare_field("action", want.action, action);
				compare_field("char_code", want.char_code, char_code);
				compare_field("stored", want.stored, stored);
				compare_field("store_index", want.store_index, store_index);
				compare_field("line_length", want.line_length, line_length);
				case (want.action)
					ACT_BACKSPACE: n_backspace++;
					ACT_ENTER: n_enter++;
					default: begin
						n_echo++;
						if (want.stored)
							n_stored++;
						else
							n_full++;
					end
				endcase
			end
		end
	end

	initial begin
		key_row_t row;
		line_event_t ev;
		bit emits;

		for (int c = 1; c < SC_MAP_SIZE; c++)
			if (lower_keys[c] != 8'h00 && c != KEY_BACKSPACE && c != KEY_ENTER)
				printable_codes.push_back(8'(c));

		// Rows with the result written out are the ones that follow directly from reset.
		key_table.push_back(typed_row(KEY_ENTER, 1'b1, ACT_ENTER, CH_ENTER, 1'b0, 6'd0, 6'd0));
		key_table.push_back(typed_row(KEY_BACKSPACE, 1'b1, ACT_BACKSPACE, CH_BACKSPACE,
			1'b0, 6'd0, 6'd0));
		key_table.push_back(typed_row(KEY_NONE, 1'b0, ACT_ECHO, CH_NONE, 1'b0, 6'd0, 6'd0));
		key_table.push_back(typed_row(KEY_ALL_ONES, 1'b0, ACT_ECHO, CH_NONE, 1'b0, 6'd0, 6'd0));
		key_table.push_back(typed_row(KEY_TOP_PRESS, 1'b0, ACT_ECHO, CH_NONE, 1'b0, 6'd0, 6'd0));
		key_table.push_back(typed_row(KEY_F1, 1'b0, ACT_ECHO, CH_NONE, 1'b0, 6'd0, 6'd0));
		key_table.push_back(typed_row(KEY_Q, 1'b1, ACT_ECHO, 7'h71, 1'b1, 6'd0, 6'd1));
		key_table.push_back(typed_row(SC_LSHIFT_MAKE, 1'b0, ACT_ECHO, CH_NONE, 1'b0, 6'd0, 6'd0));
		key_table.push_back(free_row(KEY_Q));
		key_table.push_back(free_row(KEY_ONE));
		key_table.push_back(typed_row(SC_LSHIFT_BREAK, 1'b0, ACT_ECHO, CH_NONE,
			1'b0, 6'd0, 6'd0));
		key_table.push_back(typed_row(SC_CAPS_LOCK, 1'b0, ACT_ECHO, CH_NONE, 1'b0, 6'd0, 6'd0));
		key_table.push_back(free_row(KEY_LBRACKET));
		key_table.push_back(free_row(KEY_ONE));
		key_table.push_back(free_row(SC_RSHIFT_MAKE));
		key_table.push_back(free_row(KEY_A));
		key_table.push_back(free_row(KEY_SLASH));
		key_table.push_back(free_row(SC_RSHIFT_BREAK));
		key_table.push_back(free_row(SC_CAPS_LOCK));
		key_table.push_back(free_row(KEY_SPACE));
		key_table.push_back(free_row(KEY_STAR));
		key_table.push_back(free_row(KEY_ESC));
		key_table.push_back(free_row(KEY_TAB));
		key_table.push_back(free_row(KEY_RELEASE | KEY_Q));
		key_table.push_back(free_row(KEY_BACKSPACE));
		key_table.push_back(free_row(KEY_ENTER));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (key_table[i]) begin
			row = key_table[i];
			send_code(row.code);
			emits = decode_key(row.code, ev);
			if (row.typed) begin
				emits = row.emit;
				ev = row.ev;
			end
			if (emits) begin
				pending_events.push_back(ev);
				results_expected++;
			end
		end
		drain_results();

		while (items_sent < TARGET_ITEMS) begin
			type_line();
			lines_typed++;
			if (lines_typed % 9 == 0)
				drain_results();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d scancodes: %0d table keys, then %0d random lines; %0d results checked.",
			items_sent, key_table.size(), lines_typed, results_expected);
		$display("Echoes %0d (stored %0d, full line %0d), backspaces %0d, enters %0d.",
			n_echo, n_stored, n_full, n_backspace, n_enter);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> sim.f
hdl/scla_pkg.sv
hdl/scla_decode.sv
hdl/scancode_to_ascii_line_editor_top.sv
hdl/scla_checker.sv
bench/testbench.sv
